@@ sv/pma_pkg.sv @@
// ----------------------------------------------------------------------------
// pma_pkg
// Shared constants of the paired moving-average block: default window
// lengths, sample width and the pair selector codes.
// ----------------------------------------------------------------------------
package pma_pkg;

  localparam int unsigned LONG_WINDOW_DEF  = 32;
  localparam int unsigned SHORT_WINDOW_DEF = 4;
  localparam int unsigned SAMPLE_BITS_DEF  = 12;

  localparam logic OP_PAIR_LOW  = 1'b0;
  localparam logic OP_PAIR_HIGH = 1'b1;

endpackage

@@ sv/pma_if.sv @@
// ----------------------------------------------------------------------------
// pma_if
// Valid/ready channels of the paired moving-average block: the sample pair
// channel and the average pair channel.
// ----------------------------------------------------------------------------
interface pma_in_if #(
  parameter int unsigned SAMPLE_BITS = pma_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;

  modport source (output valid, output op, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input op, input sample_a, input sample_b, output ready);
endinterface

interface pma_out_if #(
  parameter int unsigned SAMPLE_BITS = pma_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   pair;
  logic [SAMPLE_BITS-1:0] avg_a;
  logic [SAMPLE_BITS-1:0] avg_b;

  modport source (output valid, output pair, output avg_a, output avg_b, input ready);
  modport sink   (input valid, input pair, input avg_a, input avg_b, output ready);
endinterface

@@ sv/paired_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// paired_moving_average_top
// Boxcar running averages of four converter channels taken two at a time.
//
// in_ch carries one sample pair per transaction: op low feeds channels 0
// and 1, op high feeds channels 2 and 3. out_ch returns one transaction per
// input transaction, in order: pair echoes op, avg_a and avg_b are the
// truncated window averages after the new samples are taken in. Channels
// 0 to 2 average over LONG_WINDOW samples, channel 3 over SHORT_WINDOW.
// One transaction is taken every cycle while out_ch does not stall. The path
// runs through an input register, a stage that reads the rings and updates
// the sums, and a stage that divides the sums by reciprocal multiply into the
// output register. Reset empties the pipeline, zeroes every sum and marks
// every ring empty, so averages ramp up from zero until a full window has
// arrived. When out_ch is stalled the stages fill up to three transactions,
// then in_ch.ready drops.
// ----------------------------------------------------------------------------
module paired_moving_average_top #(
  parameter int unsigned LONG_WINDOW  = pma_pkg::LONG_WINDOW_DEF,
  parameter int unsigned SHORT_WINDOW = pma_pkg::SHORT_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS  = pma_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pma_in_if.sink     in_ch,
  pma_out_if.source  out_ch
);

  localparam int unsigned LSUM_W = SAMPLE_BITS + $clog2(LONG_WINDOW);
  localparam int unsigned SSUM_W = SAMPLE_BITS + $clog2(SHORT_WINDOW);

  logic                   accept;
  logic                   acc_low;
  logic                   acc_high;
  logic                   s0_free;
  logic                   s0_adv;
  logic                   s1_free;
  logic                   s1_adv;
  logic                   out_free;
  logic                   wr_low;
  logic                   wr_high;

  logic                   s0_valid_r;
  logic                   s0_op_r;
  logic [SAMPLE_BITS-1:0] s0_a_r;
  logic [SAMPLE_BITS-1:0] s0_b_r;

  logic [SAMPLE_BITS-1:0] old0;
  logic [SAMPLE_BITS-1:0] old1;
  logic [SAMPLE_BITS-1:0] old2;
  logic [SAMPLE_BITS-1:0] old3;
  logic [SAMPLE_BITS-1:0] old_a;

  logic [LSUM_W-1:0]      sum0_r;
  logic [LSUM_W-1:0]      sum1_r;
  logic [LSUM_W-1:0]      sum2_r;
  logic [SSUM_W-1:0]      sum3_r;
  logic [LSUM_W-1:0]      sum_a_cur;
  logic [LSUM_W-1:0]      sum_a_nxt;
  logic [LSUM_W-1:0]      sum1_nxt;
  logic [SSUM_W-1:0]      sum3_nxt;

  logic                   s1_valid_r;
  logic                   s1_pair_r;
  logic [LSUM_W-1:0]      s1_sum_a_r;
  logic [LSUM_W-1:0]      s1_sum_l_r;
  logic [SSUM_W-1:0]      s1_sum_s_r;

  logic [SAMPLE_BITS-1:0] q_a;
  logic [SAMPLE_BITS-1:0] q_bl;
  logic [SAMPLE_BITS-1:0] q_bs;

  logic                   out_valid_r;
  logic                   out_pair_r;
  logic [SAMPLE_BITS-1:0] out_avg_a_r;
  logic [SAMPLE_BITS-1:0] out_avg_b_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || out_free;
  assign s0_adv   = s0_valid_r && s1_free;
  assign s0_free  = !s0_valid_r || s1_free;

  assign in_ch.ready = s0_free;
  assign accept      = in_ch.valid && s0_free;
  assign acc_low     = accept && (in_ch.op == pma_pkg::OP_PAIR_LOW);
  assign acc_high    = accept && (in_ch.op == pma_pkg::OP_PAIR_HIGH);
  assign wr_low      = s0_adv && (s0_op_r == pma_pkg::OP_PAIR_LOW);
  assign wr_high     = s0_adv && (s0_op_r == pma_pkg::OP_PAIR_HIGH);

  pma_ring #(.DEPTH(LONG_WINDOW), .WIDTH(SAMPLE_BITS)) u_ring0 (
    .clk(clk), .rst_n(rst_n), .rd_en(acc_low), .wr_en(wr_low),
    .wr_data(s0_a_r), .old_data(old0)
  );

  pma_ring #(.DEPTH(LONG_WINDOW), .WIDTH(SAMPLE_BITS)) u_ring1 (
    .clk(clk), .rst_n(rst_n), .rd_en(acc_low), .wr_en(wr_low),
    .wr_data(s0_b_r), .old_data(old1)
  );

  pma_ring #(.DEPTH(LONG_WINDOW), .WIDTH(SAMPLE_BITS)) u_ring2 (
    .clk(clk), .rst_n(rst_n), .rd_en(acc_high), .wr_en(wr_high),
    .wr_data(s0_a_r), .old_data(old2)
  );

  pma_ring #(.DEPTH(SHORT_WINDOW), .WIDTH(SAMPLE_BITS)) u_ring3 (
    .clk(clk), .rst_n(rst_n), .rd_en(acc_high), .wr_en(wr_high),
    .wr_data(s0_b_r), .old_data(old3)
  );

  assign old_a     = (s0_op_r == pma_pkg::OP_PAIR_HIGH) ? old2 : old0;
  assign sum_a_cur = (s0_op_r == pma_pkg::OP_PAIR_HIGH) ? sum2_r : sum0_r;
  assign sum_a_nxt = sum_a_cur + LSUM_W'(s0_a_r) - LSUM_W'(old_a);
  assign sum1_nxt  = sum1_r + LSUM_W'(s0_b_r) - LSUM_W'(old1);
  assign sum3_nxt  = sum3_r + SSUM_W'(s0_b_r) - SSUM_W'(old3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum0_r      <= '0;
      sum1_r      <= '0;
      sum2_r      <= '0;
      sum3_r      <= '0;
    end else begin
      if (s0_free) begin
        s0_valid_r <= in_ch.valid;
      end
      if (s1_free) begin
        s1_valid_r <= s0_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (wr_low) begin
        sum0_r <= sum_a_nxt;
        sum1_r <= sum1_nxt;
      end
      if (wr_high) begin
        sum2_r <= sum_a_nxt;
        sum3_r <= sum3_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_op_r <= in_ch.op;
      s0_a_r  <= in_ch.sample_a;
      s0_b_r  <= in_ch.sample_b;
    end
    if (s0_adv) begin
      s1_pair_r  <= s0_op_r;
      s1_sum_a_r <= sum_a_nxt;
      s1_sum_l_r <= sum1_nxt;
      s1_sum_s_r <= sum3_nxt;
    end
    if (s1_adv) begin
      out_pair_r  <= s1_pair_r;
      out_avg_a_r <= q_a;
      out_avg_b_r <= (s1_pair_r == pma_pkg::OP_PAIR_HIGH) ? q_bs : q_bl;
    end
  end

  pma_div #(.DIVISOR(LONG_WINDOW), .IN_W(LSUM_W), .OUT_W(SAMPLE_BITS)) u_div_a (
    .dividend(s1_sum_a_r), .quotient(q_a)
  );

  pma_div #(.DIVISOR(LONG_WINDOW), .IN_W(LSUM_W), .OUT_W(SAMPLE_BITS)) u_div_bl (
    .dividend(s1_sum_l_r), .quotient(q_bl)
  );

  pma_div #(.DIVISOR(SHORT_WINDOW), .IN_W(SSUM_W), .OUT_W(SAMPLE_BITS)) u_div_bs (
    .dividend(s1_sum_s_r), .quotient(q_bs)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.pair  = out_pair_r;
  assign out_ch.avg_a = out_avg_a_r;
  assign out_ch.avg_b = out_avg_b_r;

endmodule

@@ sv/pma_ring.sv @@
// ----------------------------------------------------------------------------
// pma_ring
// Sample ring of one channel: a memory with a registered read of the oldest
// sample, a write pointer and a fill flag that makes unwritten slots read
// as zero.
// ----------------------------------------------------------------------------
module pma_ring #(
  parameter int unsigned DEPTH = pma_pkg::LONG_WINDOW_DEF,
  parameter int unsigned WIDTH = pma_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] old_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    ptr_r;
  logic [AW-1:0]    ptr_nxt;
  logic             full_r;
  logic             full_nxt;
  logic             rd_live_r;
  logic [AW-1:0]    wr_addr_r;
  logic [WIDTH-1:0] rd_data_r;

  assign ptr_nxt  = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
  assign full_nxt = full_r | (ptr_r == LAST);
  assign old_data = rd_live_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      full_r    <= 1'b0;
      rd_live_r <= 1'b0;
    end else if (rd_en) begin
      ptr_r     <= ptr_nxt;
      full_r    <= full_nxt;
      rd_live_r <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_r];
      wr_addr_r <= ptr_r;
    end
  end

endmodule

@@ sv/pma_div.sv @@
// ----------------------------------------------------------------------------
// pma_div
// Truncating division of a window sum by the constant window length,
// done as a multiply by a rounded-up reciprocal and a shift.
// ----------------------------------------------------------------------------
module pma_div #(
  parameter int unsigned DIVISOR = pma_pkg::LONG_WINDOW_DEF,
  parameter int unsigned IN_W    = pma_pkg::SAMPLE_BITS_DEF + $clog2(pma_pkg::LONG_WINDOW_DEF),
  parameter int unsigned OUT_W   = pma_pkg::SAMPLE_BITS_DEF
) (
  input  logic [IN_W-1:0]  dividend,
  output logic [OUT_W-1:0] quotient
);

  localparam int unsigned SHIFT  = IN_W + $clog2(DIVISOR);
  localparam int unsigned MW     = IN_W + 1;
  localparam int unsigned PW     = IN_W + MW;
  localparam logic [63:0] MULT64 = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MULT = MULT64[MW-1:0];

  logic [PW-1:0] product;

  assign product  = PW'(dividend) * PW'(MULT);
  assign quotient = product[SHIFT +: OUT_W];

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of the paired moving-average block. Sample pairs go in over the
// in_ch valid/ready channel and average pairs come back over out_ch. A
// scoreboard keeps its own rings and running sums for all four channels,
// works out the expected averages of each accepted transaction and compares
// every returned transaction field by field, in order. Stimulus is a short
// directed set followed by random bursts of constant, near-full, one-hot or
// uniform samples, run under several sender and receiver throttling phases,
// a long receiver hold-off and full drains between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_BITS_DEF  = pma_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned LONG_WINDOW_DEF  = pma_pkg::LONG_WINDOW_DEF;
  localparam int unsigned SHORT_WINDOW_DEF = pma_pkg::SHORT_WINDOW_DEF;

  typedef struct packed {
    logic                       pair;
    logic [SAMPLE_BITS_DEF-1:0] avg_a;
    logic [SAMPLE_BITS_DEF-1:0] avg_b;
  } avg_pair_t;

  typedef enum int unsigned {
    STYLE_UNIFORM,
    STYLE_FULL,
    STYLE_ZERO,
    STYLE_HIGH,
    STYLE_ONE_HOT
  } sample_style_t;

  class avg_scoreboard;
    bit [SAMPLE_BITS_DEF-1:0] ring_ch0[LONG_WINDOW_DEF];
    bit [SAMPLE_BITS_DEF-1:0] ring_ch1[LONG_WINDOW_DEF];
    bit [SAMPLE_BITS_DEF-1:0] ring_ch2[LONG_WINDOW_DEF];
    bit [SAMPLE_BITS_DEF-1:0] ring_ch3[SHORT_WINDOW_DEF];
    int unsigned total_ch0;
    int unsigned total_ch1;
    int unsigned total_ch2;
    int unsigned total_ch3;
    int unsigned pos_first;
    int unsigned pos_second;
    int unsigned pos_short;
    avg_pair_t   expected_q[$];
    int unsigned mismatches;

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task note_pair(logic op, logic [SAMPLE_BITS_DEF-1:0] a, logic [SAMPLE_BITS_DEF-1:0] b);
      avg_pair_t   res;
      int unsigned quot_a;
      int unsigned quot_b;
      res.pair = op;
      if (op == pma_pkg::OP_PAIR_LOW) begin
        total_ch0 = total_ch0 + a - ring_ch0[pos_first];
        total_ch1 = total_ch1 + b - ring_ch1[pos_first];
        ring_ch0[pos_first] = a;
        ring_ch1[pos_first] = b;
        quot_a = total_ch0 / LONG_WINDOW_DEF;
        quot_b = total_ch1 / LONG_WINDOW_DEF;
        pos_first = (pos_first + 1) % LONG_WINDOW_DEF;
      end else begin
        total_ch2 = total_ch2 + a - ring_ch2[pos_second];
        total_ch3 = total_ch3 + b - ring_ch3[pos_short];
        ring_ch2[pos_second] = a;
        ring_ch3[pos_short] = b;
        quot_a = total_ch2 / LONG_WINDOW_DEF;
        quot_b = total_ch3 / SHORT_WINDOW_DEF;
        pos_second = (pos_second + 1) % LONG_WINDOW_DEF;
        pos_short = (pos_short + 1) % SHORT_WINDOW_DEF;
      end
      res.avg_a = quot_a[SAMPLE_BITS_DEF-1:0];
      res.avg_b = quot_b[SAMPLE_BITS_DEF-1:0];
      expected_q.push_back(res);
    endtask

    task check_average(logic pair, logic [SAMPLE_BITS_DEF-1:0] a,
                       logic [SAMPLE_BITS_DEF-1:0] b);
      avg_pair_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction pair=%0d avg_a=%0d avg_b=%0d", pair, a, b));
      end else begin
        exp_res = expected_q.pop_front();
        if (pair !== exp_res.pair)
          report($sformatf("pair %0d, want %0d", pair, exp_res.pair));
        if (a !== exp_res.avg_a)
          report($sformatf("avg_a %0d, want %0d (pair %0d)", a, exp_res.avg_a, exp_res.pair));
        if (b !== exp_res.avg_b)
          report($sformatf("avg_b %0d, want %0d (pair %0d)", b, exp_res.avg_b, exp_res.pair));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned rx_holdoff_left;

  avg_scoreboard sb;

  pma_in_if  in_ch ();
  pma_out_if out_ch ();

  paired_moving_average_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(2_400_000);
    $display("FAILED: results differ");
    $finish;
  end

  // receiver side: stall at random, or hold off for a counted stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_holdoff_left > 0) begin
        out_ch.ready = 1'b0;
        rx_holdoff_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_average(out_ch.pair, out_ch.avg_a, out_ch.avg_b);
    end
  end

  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(sample_style_t style);
    logic [SAMPLE_BITS_DEF-1:0] val;
    case (style)
      STYLE_FULL:    val = '1;
      STYLE_ZERO:    val = '0;
      STYLE_HIGH:    val = 12'($urandom_range(4095, 4032));
      STYLE_ONE_HOT: val = 12'(1) << $urandom_range(SAMPLE_BITS_DEF-1);
      default:       val = 12'($urandom_range(4095));
    endcase
    return val;
  endfunction

  task automatic drive_pair(logic op, logic [SAMPLE_BITS_DEF-1:0] a,
                            logic [SAMPLE_BITS_DEF-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.op       = op;
    in_ch.sample_a = a;
    in_ch.sample_b = b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pair(op, a, b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_bursts(int unsigned count);
    int unsigned   done;
    int unsigned   run_len;
    int unsigned   k;
    sample_style_t style_a;
    sample_style_t style_b;
    bit            op_mixed;
    logic          op_fixed;
    logic          op;
    done = 0;
    while (done < count) begin
      run_len  = $urandom_range(70, 1);
      style_a  = sample_style_t'($urandom_range(4));
      style_b  = sample_style_t'($urandom_range(4));
      op_mixed = ($urandom_range(2) == 0);
      op_fixed = 1'($urandom_range(1));
      for (k = 0; k < run_len && done < count; k++) begin
        op = op_mixed ? logic'($urandom_range(1)) : op_fixed;
        drive_pair(op, pick_sample(style_a), pick_sample(style_b));
        done++;
      end
    end
  endtask

  initial begin
    sb              = new();
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    rx_holdoff_left = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = pma_pkg::OP_PAIR_LOW;
    in_ch.sample_a  = '0;
    in_ch.sample_b  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // start-up ramp, extremes and short-window fill
    drive_pair(pma_pkg::OP_PAIR_LOW,  12'd0,    12'd0);
    drive_pair(pma_pkg::OP_PAIR_HIGH, 12'd0,    12'd0);
    drive_pair(pma_pkg::OP_PAIR_LOW,  12'hFFF,  12'hFFF);
    drive_pair(pma_pkg::OP_PAIR_HIGH, 12'hFFF,  12'hFFF);
    repeat (3) drive_pair(pma_pkg::OP_PAIR_HIGH, 12'hFFF, 12'hFFF);
    drive_pair(pma_pkg::OP_PAIR_HIGH, 12'd0,    12'd0);
    drive_pair(pma_pkg::OP_PAIR_LOW,  12'h800,  12'h001);
    drive_pair(pma_pkg::OP_PAIR_HIGH, 12'h001,  12'h800);
    drive_pair(pma_pkg::OP_PAIR_LOW,  12'hAAA,  12'h555);
    drive_pair(pma_pkg::OP_PAIR_HIGH, 12'h555,  12'hAAA);
    drive_pair(pma_pkg::OP_PAIR_LOW,  12'hFFF,  12'd0);
    drive_pair(pma_pkg::OP_PAIR_LOW,  12'd0,    12'hFFF);
    repeat (4) drive_pair(pma_pkg::OP_PAIR_HIGH, 12'd0, 12'hFFF);
    wait_drained();

    run_bursts(270);
    wait_drained();

    // hold the receiver off while the sender keeps offering
    rx_holdoff_left = 150;
    run_bursts(40);
    wait_drained();

    tx_idle_pct  = 82;
    rx_stall_pct = 0;
    run_bursts(270);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 82;
    run_bursts(270);
    wait_drained();

    tx_idle_pct  = 17;
    rx_stall_pct = 17;
    run_bursts(270);
    wait_drained();

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
